// ===== src/dcld_pkg.sv =====
// Shared types, widths, codes and helpers of the display command line decoder.
// No dependencies; every other file imports this package.
package dcld_pkg;

    // Field widths
    localparam int CH_W       = 8;
    localparam int VALUE_W    = 14;
    localparam int HEX_W      = 8;
    localparam int TEXT_W     = 64;
    localparam int TEXT_BYTES = TEXT_W / 8;
    localparam int TEXT_LEN_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int TOK_W      = 3;
    localparam int NUM_PARAMS = 4;

    // Default token length limit and register reset values
    localparam int PARAM_LEN_DEFAULT = 8;
    localparam logic [VALUE_W-1:0] FLICK_MIN_RESET = VALUE_W'(100);
    localparam logic [VALUE_W-1:0] FLICK_MAX_RESET = VALUE_W'(2000);
    localparam logic [VALUE_W-1:0] LIGHT_MAX_RESET = VALUE_W'(10);

    // Special characters
    localparam logic [CH_W-1:0] CH_END   = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

    // Token positions within a line
    localparam logic [TOK_W-1:0] TOK_COMMAND    = TOK_W'(0);
    localparam logic [TOK_W-1:0] TOK_LAST_PARAM = TOK_W'(NUM_PARAMS);

    typedef enum logic [2:0] {
        RSP_OK          = 3'd0,
        RSP_BAD_COMMAND = 3'd1,
        RSP_BAD_PARAM   = 3'd2,
        RSP_TOO_LONG    = 3'd3,
        RSP_HELP        = 3'd4
    } t_reply;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_DISP  = 3'd1,
        OP_FLICK = 3'd2,
        OP_LIGHT = 3'd3,
        OP_CODE  = 3'd4,
        OP_HELP  = 3'd5
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLICK_MIN = 2'd0,
        CFG_FLICK_MAX = 2'd1,
        CFG_LIGHT_MAX = 2'd2
    } t_cfg_index;

    // Fold a lowercase letter to uppercase
    function automatic logic [CH_W-1:0] to_upper(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]}) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    // Match the command token; bytes holds the first character in its lowest byte
    function automatic t_command match_command(input logic [TEXT_W-1:0] bytes,
                                               input logic [TEXT_LEN_W-1:0] len);
        logic [31:0] key4;
        logic [39:0] key5;
        t_command    r;
        key4 = {to_upper(bytes[7:0]), to_upper(bytes[15:8]),
                to_upper(bytes[23:16]), to_upper(bytes[31:24])};
        key5 = {key4, to_upper(bytes[39:32])};
        r = OP_NONE;
        if (len == TEXT_LEN_W'(4)) begin
            if (key4 == "DISP") begin
                r = OP_DISP;
            end else if (key4 == "CODE") begin
                r = OP_CODE;
            end else if (key4 == "HELP") begin
                r = OP_HELP;
            end
        end else if (len == TEXT_LEN_W'(5)) begin
            if (key5 == "FLICK") begin
                r = OP_FLICK;
            end else if (key5 == "LIGHT") begin
                r = OP_LIGHT;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/dcld_if.sv =====
// Handshake channels of the display command line decoder: characters in,
// line results out, register writes. Depends on dcld_pkg.
interface dcld_in_if import dcld_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface dcld_out_if import dcld_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [2:0]            reply;
    logic [2:0]            command;
    logic                  apply;
    logic [VALUE_W-1:0]    value1;
    logic [VALUE_W-1:0]    value2;
    logic [VALUE_W-1:0]    value3;
    logic [VALUE_W-1:0]    value4;
    logic [TEXT_W-1:0]     text;
    logic [TEXT_LEN_W-1:0] text_len;

    modport source (output valid, output reply, output command, output apply,
                    output value1, output value2, output value3, output value4,
                    output text, output text_len, input ready);
    modport sink   (input valid, input reply, input command, input apply,
                    input value1, input value2, input value3, input value4,
                    input text, input text_len, output ready);
endinterface

interface dcld_cfg_if import dcld_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VALUE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/display_command_line_decoder_core.sv =====
// Display command line decoder: character parser, command match, limit checks.
// Depends on dcld_pkg and the channel interfaces in dcld_if.sv.
//
// Takes one character per clock cycle. Each accepted character updates the
// token parsing registers in that same cycle; the end-of-line byte (zero)
// feeds the command match and parameter checks straight into a one-word
// output register, so the line result is offered on the cycle after the zero
// byte is taken. Characters keep flowing while the output register is free or
// being drained in the same cycle; only a held, untaken result stalls input.
// Register writes are taken at any time (ready is tied high) and should only
// be issued between lines.
module display_command_line_decoder_core import dcld_pkg::*; #(
    parameter int PARAM_LEN = PARAM_LEN_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dcld_in_if.sink           i_in,
    dcld_out_if.source        o_out,
    dcld_cfg_if.sink          i_cfg
);

    localparam int LEN_W = $clog2(PARAM_LEN + 1);
    localparam int IDX_W = (PARAM_LEN > 1) ? $clog2(PARAM_LEN) : 1;

    // Configuration registers
    logic [VALUE_W-1:0] r_flick_min;
    logic [VALUE_W-1:0] r_flick_max;
    logic [VALUE_W-1:0] r_light_max;

    // Line parsing state
    logic [TOK_W-1:0]   r_tok;
    logic [LEN_W-1:0]   r_len;
    logic               r_overlong;
    logic [CH_W-1:0]    r_cmd_chars [PARAM_LEN];
    logic [LEN_W-1:0]   r_cmd_len;
    logic [CH_W-1:0]    r_disp_chars [PARAM_LEN];
    logic [LEN_W-1:0]   r_disp_len;
    logic [VALUE_W-1:0] r_dec [NUM_PARAMS];
    logic               r_dec_ok [NUM_PARAMS];
    logic [HEX_W-1:0]   r_hex [NUM_PARAMS];
    logic               r_hex_ok [NUM_PARAMS];

    // Output register
    logic                  r_out_valid;
    t_reply                r_reply;
    t_command              r_command;
    logic                  r_apply;
    logic [VALUE_W-1:0]    r_value [NUM_PARAMS];
    logic [TEXT_W-1:0]     r_text;
    logic [TEXT_LEN_W-1:0] r_text_len;

    logic                  w_in_take;
    logic                  w_line_end;
    logic                  w_out_free;

    // Handshakes
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = w_out_free;
    assign i_cfg.ready = 1'b1;
    assign w_in_take  = i_in.valid && w_out_free;
    assign w_line_end = w_in_take && (i_in.ch == CH_END);

    // Write configuration registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flick_min <= FLICK_MIN_RESET;
            r_flick_max <= FLICK_MAX_RESET;
            r_light_max <= LIGHT_MAX_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_FLICK_MIN: r_flick_min <= i_cfg.data;
                CFG_FLICK_MAX: r_flick_max <= i_cfg.data;
                CFG_LIGHT_MAX: r_light_max <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Classify the incoming character
    logic               w_is_digit;
    logic [3:0]         w_digit;
    logic               w_is_hex;
    logic [3:0]         w_hex_digit;
    logic [LEN_W-1:0]   w_limit;
    logic               w_active;
    logic               w_store;
    logic [TOK_W-1:0]   w_param;
    logic [IDX_W-1:0]   w_pos;

    always_comb begin
        w_is_digit  = i_in.ch inside {[8'h30:8'h39]};
        w_digit     = 4'(i_in.ch - 8'h30);
        w_is_hex    = 1'b1;
        w_hex_digit = w_digit;
        if (i_in.ch inside {[8'h41:8'h46]}) begin
            w_hex_digit = 4'(i_in.ch - 8'h41 + 8'd10);
        end else if (i_in.ch inside {[8'h61:8'h66]}) begin
            w_hex_digit = 4'(i_in.ch - 8'h61 + 8'd10);
        end else if (!w_is_digit) begin
            w_is_hex = 1'b0;
        end
        w_limit  = (r_tok == TOK_LAST_PARAM) ? LEN_W'(PARAM_LEN - 1) : LEN_W'(PARAM_LEN);
        w_active = w_in_take && !w_line_end && !r_overlong && (r_tok <= TOK_LAST_PARAM);
        w_store  = w_active && (i_in.ch != CH_SPACE) && (r_len < w_limit);
        w_param  = r_tok - TOK_W'(1);
        w_pos    = r_len[IDX_W-1:0];
    end

    // Advance token position, length and overlong flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok      <= TOK_COMMAND;
            r_len      <= '0;
            r_overlong <= 1'b0;
            r_cmd_len  <= '0;
            r_disp_len <= '0;
        end else if (w_line_end) begin
            r_tok      <= TOK_COMMAND;
            r_len      <= '0;
            r_overlong <= 1'b0;
            r_cmd_len  <= '0;
            r_disp_len <= '0;
        end else if (w_active) begin
            if (i_in.ch == CH_SPACE) begin
                r_tok <= r_tok + TOK_W'(1);
                r_len <= '0;
            end else if (!w_store) begin
                r_overlong <= 1'b1;
            end else begin
                r_len <= r_len + LEN_W'(1);
                if (r_tok == TOK_COMMAND) begin
                    r_cmd_len <= r_len + LEN_W'(1);
                end else if (w_param == TOK_W'(0)) begin
                    r_disp_len <= r_len + LEN_W'(1);
                end
            end
        end
    end

    // Store command and display characters
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            if (r_tok == TOK_COMMAND) begin
                r_cmd_chars[w_pos] <= i_in.ch;
            end else if (w_param == TOK_W'(0)) begin
                r_disp_chars[w_pos] <= i_in.ch;
            end
        end
    end

    // Accumulate each parameter as decimal and as hex
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_PARAMS; k++) begin
            if (!i_rst_n || w_line_end) begin
                r_dec[k]    <= '0;
                r_dec_ok[k] <= 1'b1;
                r_hex[k]    <= '0;
                r_hex_ok[k] <= 1'b1;
            end else if (w_store && (r_tok != TOK_COMMAND) && (w_param == TOK_W'(k))) begin
                if (w_is_digit && (r_len < LEN_W'(4))) begin
                    if (r_dec_ok[k]) begin
                        r_dec[k] <= (r_dec[k] << 3) + (r_dec[k] << 1) + VALUE_W'(w_digit);
                    end
                end else begin
                    r_dec_ok[k] <= 1'b0;
                end
                if (w_is_hex && (r_len < LEN_W'(2))) begin
                    if (r_hex_ok[k]) begin
                        r_hex[k] <= {r_hex[k][3:0], w_hex_digit};
                    end
                end else begin
                    r_hex_ok[k] <= 1'b0;
                end
            end
        end
    end

    // Gather stored characters into byte vectors; display bytes past its length and bytes past PARAM_LEN are zero
    logic [TEXT_W-1:0] w_cmd_bytes;
    logic [TEXT_W-1:0] w_disp_bytes;

    for (genvar i = 0; i < TEXT_BYTES; i++) begin : g_bytes
        if (i < PARAM_LEN) begin : g_used
            assign w_cmd_bytes[8*i +: 8]  = r_cmd_chars[i];
            assign w_disp_bytes[8*i +: 8] = (LEN_W'(i) < r_disp_len) ? r_disp_chars[i] : '0;
        end else begin : g_unused
            assign w_cmd_bytes[8*i +: 8]  = '0;
            assign w_disp_bytes[8*i +: 8] = '0;
        end
    end

    // Decode the finished line
    t_command              n_command;
    t_reply                n_reply;
    logic                  n_apply;
    logic [VALUE_W-1:0]    n_value [NUM_PARAMS];
    logic [TEXT_W-1:0]     n_text;
    logic [TEXT_LEN_W-1:0] n_text_len;
    logic                  w_dec_good;
    logic                  w_hex_good;

    always_comb begin
        w_dec_good = 1'b1;
        w_hex_good = 1'b1;
        n_command  = match_command(w_cmd_bytes, TEXT_LEN_W'(r_cmd_len));
        for (int k = 0; k < NUM_PARAMS; k++) begin
            if (!r_dec_ok[k]) begin
                w_dec_good = 1'b0;
            end else if ((n_command == OP_FLICK) && (r_dec[k] != '0) &&
                         ((r_dec[k] < r_flick_min) || (r_dec[k] > r_flick_max))) begin
                w_dec_good = 1'b0;
            end else if ((n_command == OP_LIGHT) && (r_dec[k] > r_light_max)) begin
                w_dec_good = 1'b0;
            end
            if (!r_hex_ok[k]) begin
                w_hex_good = 1'b0;
            end
        end

        n_reply    = RSP_OK;
        n_apply    = 1'b0;
        n_text     = '0;
        n_text_len = '0;
        for (int k = 0; k < NUM_PARAMS; k++) begin
            n_value[k] = '0;
        end

        if (r_overlong) begin
            n_reply   = RSP_TOO_LONG;
            n_command = OP_NONE;
        end else begin
            case (n_command)
                OP_DISP: begin
                    n_apply    = 1'b1;
                    n_text     = w_disp_bytes;
                    n_text_len = TEXT_LEN_W'(r_disp_len);
                end
                OP_FLICK, OP_LIGHT: begin
                    if (w_dec_good) begin
                        n_apply = 1'b1;
                        for (int k = 0; k < NUM_PARAMS; k++) begin
                            n_value[k] = r_dec[k];
                        end
                    end else begin
                        n_reply = RSP_BAD_PARAM;
                    end
                end
                OP_CODE: begin
                    if (w_hex_good) begin
                        n_apply = 1'b1;
                        for (int k = 0; k < NUM_PARAMS; k++) begin
                            n_value[k] = VALUE_W'(r_hex[k]);
                        end
                    end else begin
                        n_reply = RSP_BAD_PARAM;
                    end
                end
                OP_HELP: n_reply = RSP_HELP;
                default: n_reply = RSP_BAD_COMMAND;
            endcase
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_line_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_line_end) begin
            r_reply    <= n_reply;
            r_command  <= n_command;
            r_apply    <= n_apply;
            r_value    <= n_value;
            r_text     <= n_text;
            r_text_len <= n_text_len;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.reply    = r_reply;
    assign o_out.command  = r_command;
    assign o_out.apply    = r_apply;
    assign o_out.value1   = r_value[0];
    assign o_out.value2   = r_value[1];
    assign o_out.value3   = r_value[2];
    assign o_out.value4   = r_value[3];
    assign o_out.text     = r_text;
    assign o_out.text_len = r_text_len;

endmodule

// ===== bench/tb_display_command_line_decoder_core.sv =====
// Self-checking bench for display_command_line_decoder_core: sends command lines a
// character at a time, predicts each line result and checks it field by field.
// Depends on dcld_pkg, the channel interfaces in dcld_if.sv and the core itself.
module tb_display_command_line_decoder_core import dcld_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_MAX    = PARAM_LEN_DEFAULT;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_CHARS = 1500;
    localparam int RANDOM_PHASES = 6;

    localparam logic [CH_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CH_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;

    typedef struct packed {
        t_reply                          reply;
        t_command                        command;
        logic                            apply;
        logic [NUM_PARAMS-1:0][VALUE_W-1:0] values;
        logic [TEXT_W-1:0]               text;
        logic [TEXT_LEN_W-1:0]           text_len;
    } t_line_result;

    logic i_clk;
    logic i_rst_n;

    dcld_in_if  in_if ();
    dcld_out_if out_if ();
    dcld_cfg_if cfg_if ();

    display_command_line_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Mirror of the decoder: limits and per-line parsing state
    logic [VALUE_W-1:0]    flick_lo, flick_hi, light_hi;
    logic [TOK_W-1:0]      tok_idx;
    logic [3:0]            tok_len;
    logic                  too_long;
    logic [CH_W-1:0]       cmd_bytes  [TEXT_BYTES];
    logic [TEXT_LEN_W-1:0] cmd_len;
    logic [CH_W-1:0]       disp_bytes [TEXT_BYTES];
    logic [TEXT_LEN_W-1:0] disp_len;
    logic [VALUE_W-1:0]    dec_val  [NUM_PARAMS];
    logic                  dec_good [NUM_PARAMS];
    logic [HEX_W-1:0]      hex_val  [NUM_PARAMS];
    logic                  hex_good [NUM_PARAMS];

    t_line_result pending_lines[$];
    int           chars_sent;
    int           mismatches;
    int           cycle_count;
    int           burst_left;
    bit           gaps_on;
    bit           hold_req;
    int unsigned  rx_phase;
    int unsigned  rx_mode;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] fold_upper(input logic [CH_W-1:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - 8'd32 : c;
    endfunction

    function automatic void clear_line_state();
        tok_idx  = TOK_COMMAND;
        tok_len  = '0;
        too_long = 1'b0;
        cmd_len  = '0;
        disp_len = '0;
        for (int i = 0; i < NUM_PARAMS; i++) begin
            dec_val[i]  = '0;
            dec_good[i] = 1'b1;
            hex_val[i]  = '0;
            hex_good[i] = 1'b1;
        end
    endfunction

    // Decode the command token; only exact lengths 4 and 5 can match
    function automatic t_command decode_command();
        logic [39:0] key;
        t_command    cmd;
        key = '0;
        cmd = OP_NONE;
        for (int i = 0; i < int'(cmd_len) && i < 5; i++) begin
            key = {key[31:0], fold_upper(cmd_bytes[i])};
        end
        if (cmd_len == 4) begin
            case (key[31:0])
                "DISP": cmd = OP_DISP;
                "CODE": cmd = OP_CODE;
                "HELP": cmd = OP_HELP;
                default: cmd = OP_NONE;
            endcase
        end else if (cmd_len == 5) begin
            case (key)
                "FLICK": cmd = OP_FLICK;
                "LIGHT": cmd = OP_LIGHT;
                default: cmd = OP_NONE;
            endcase
        end
        return cmd;
    endfunction

    // Work out the result of the line just ended and queue it
    function automatic void close_line();
        t_line_result r;
        logic         good;
        r    = '0;
        good = 1'b1;
        if (too_long) begin
            r.reply = RSP_TOO_LONG;
        end else begin
            r.command = decode_command();
            case (r.command)
                OP_DISP: begin
                    r.apply = 1'b1;
                    for (int i = 0; i < int'(disp_len) && i < TEXT_BYTES; i++) begin
                        r.text[8*i +: 8] = disp_bytes[i];
                    end
                    r.text_len = disp_len;
                end
                OP_FLICK, OP_LIGHT: begin
                    for (int i = 0; i < NUM_PARAMS; i++) begin
                        if (!dec_good[i]) begin
                            good = 1'b0;
                        end else if (r.command == OP_FLICK && dec_val[i] != 0 &&
                                     (dec_val[i] < flick_lo || dec_val[i] > flick_hi)) begin
                            good = 1'b0;
                        end else if (r.command == OP_LIGHT && dec_val[i] > light_hi) begin
                            good = 1'b0;
                        end
                    end
                    if (good) begin
                        r.apply = 1'b1;
                        for (int i = 0; i < NUM_PARAMS; i++) r.values[i] = dec_val[i];
                    end else begin
                        r.reply = RSP_BAD_PARAM;
                    end
                end
                OP_CODE: begin
                    for (int i = 0; i < NUM_PARAMS; i++) good &= hex_good[i];
                    if (good) begin
                        r.apply = 1'b1;
                        for (int i = 0; i < NUM_PARAMS; i++) r.values[i] = VALUE_W'(hex_val[i]);
                    end else begin
                        r.reply = RSP_BAD_PARAM;
                    end
                end
                OP_HELP: r.reply = RSP_HELP;
                default: r.reply = RSP_BAD_COMMAND;
            endcase
        end
        pending_lines.push_back(r);
    endfunction

    // Advance the mirror by one accepted character
    function automatic void predict_char(input logic [CH_W-1:0] c);
        logic [3:0] limit;
        int         p;
        int         d;
        if (c == CH_END) begin
            close_line();
            clear_line_state();
            return;
        end
        if (too_long || tok_idx > TOK_LAST_PARAM) return;
        if (c == CH_SPACE) begin
            tok_idx++;
            tok_len = '0;
            return;
        end
        limit = (tok_idx == TOK_LAST_PARAM) ? 4'(TOKEN_MAX - 1) : 4'(TOKEN_MAX);
        if (tok_len >= limit) begin
            too_long = 1'b1;
            return;
        end
        if (tok_idx == TOK_COMMAND) begin
            cmd_bytes[tok_len[2:0]] = c;
            cmd_len = tok_len + 4'd1;
        end else begin
            p = int'(tok_idx) - 1;
            if (p == 0) begin
                disp_bytes[tok_len[2:0]] = c;
                disp_len = tok_len + 4'd1;
            end
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9 && tok_len < 4) begin
                if (dec_good[p]) dec_val[p] = dec_val[p] * 10 + VALUE_W'(c - CH_DIGIT_0);
            end else begin
                dec_good[p] = 1'b0;
            end
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)      d = int'(c - CH_DIGIT_0);
            else if (c >= CH_UPPER_A && c <= CH_UPPER_F) d = int'(c - CH_UPPER_A) + 10;
            else if (c >= CH_LOWER_A && c <= CH_LOWER_F) d = int'(c - CH_LOWER_A) + 10;
            else                                         d = 16;
            if (d < 16 && tok_len < 2) begin
                if (hex_good[p]) hex_val[p] = {hex_val[p][3:0], 4'(d)};
            end else begin
                hex_good[p] = 1'b0;
            end
        end
        tok_len = tok_len + 4'd1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each taken result word with the oldest expected line result
    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_lines.size() == 0) begin
                $error("result word with no line pending");
                mismatches++;
            end else begin
                want = pending_lines.pop_front();
                check_field("reply",    want.reply,     out_if.reply);
                check_field("command",  want.command,   out_if.command);
                check_field("apply",    want.apply,     out_if.apply);
                check_field("value1",   want.values[0], out_if.value1);
                check_field("value2",   want.values[1], out_if.value2);
                check_field("value3",   want.values[2], out_if.value3);
                check_field("value4",   want.values[3], out_if.value4);
                check_field("text",     want.text,      out_if.text);
                check_field("text_len", want.text_len,  out_if.text_len);
            end
        end
    end

    // Result receiver: changing stall pattern, long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        rx_phase = 0;
        rx_mode  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (rx_phase[5:0] == 0) rx_mode = $urandom_range(0, 3);
                rx_phase++;
                case (rx_mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    2:       out_if.ready <= (rx_phase[1:0] == 0);
                    default: out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one character and hold it until taken; idle between bursts when gaps are on
    task automatic send_char(input logic [CH_W-1:0] c);
        int gap;
        in_if.valid <= 1'b1;
        in_if.ch    <= c;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_char(c);
        chars_sent++;
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 6);
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    task automatic send_line(input logic [CH_W-1:0] q[$]);
        foreach (q[i]) send_char(q[i]);
        send_char(CH_END);
    endtask

    function automatic void push_str(ref logic [CH_W-1:0] q[$], input string s,
                                     input bit mix_case);
        logic [CH_W-1:0] b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            if (mix_case && fold_upper(b) >= CH_UPPER_A && fold_upper(b) <= CH_UPPER_Z &&
                $urandom_range(0, 1) == 1) begin
                b = b ^ 8'h20;
            end
            q.push_back(b);
        end
    endfunction

    task automatic send_text(input string s);
        logic [CH_W-1:0] q[$];
        push_str(q, s, 1'b0);
        send_line(q);
    endtask

    // Stop offering and wait until every line result has been taken
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three limit registers back to back, block idle
    task automatic set_limits(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                              input logic [VALUE_W-1:0] light);
        t_cfg_index         idx  [3];
        logic [VALUE_W-1:0] data [3];
        idx  = '{CFG_FLICK_MIN, CFG_FLICK_MAX, CFG_LIGHT_MAX};
        data = '{lo, hi, light};
        for (int i = 0; i < 3; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= data[i];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            case (idx[i])
                CFG_FLICK_MIN: flick_lo = data[i];
                CFG_FLICK_MAX: flick_hi = data[i];
                default:       light_hi = data[i];
            endcase
        end
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic string random_word(input int len);
        string s;
        s = "";
        for (int i = 0; i < len; i++) s = $sformatf("%s%c", s, 8'($urandom_range(33, 126)));
        return s;
    endfunction

    function automatic string decimal_text(input int v);
        if (v < 0) v = 0;
        return ($urandom_range(0, 3) == 0) ? $sformatf("%04d", v) : $sformatf("%0d", v);
    endfunction

    // One parameter token shaped for the given command, with some broken ones
    function automatic string param_text(input t_command cmd);
        int    v;
        int    pick;
        string s;
        pick = $urandom_range(0, 15);
        if (pick == 0) return "";
        if (pick == 1) return random_word($urandom_range(1, 9));
        if (pick == 2) return $sformatf("%05d", $urandom_range(0, 99999));
        case (cmd)
            OP_FLICK: begin
                case ($urandom_range(0, 5))
                    0:       v = 0;
                    1:       v = int'(flick_lo);
                    2:       v = int'(flick_hi);
                    3:       v = int'(flick_lo) - 1;
                    4:       v = int'(flick_hi) + 1;
                    default: v = $urandom_range(0, 9999);
                endcase
                s = decimal_text(v);
            end
            OP_LIGHT: begin
                case ($urandom_range(0, 4))
                    0:       v = 0;
                    1:       v = int'(light_hi);
                    2:       v = int'(light_hi) + 1;
                    3:       v = $urandom_range(0, 9999);
                    default: v = $urandom_range(0, int'(light_hi));
                endcase
                s = decimal_text(v);
            end
            OP_CODE: begin
                v = $urandom_range(0, 255);
                case ($urandom_range(0, 3))
                    0:       s = $sformatf("%0h", v);
                    1: begin
                        s = $sformatf("%02h", v);
                        s = s.toupper();
                    end
                    2:       s = $sformatf("%03h", v);
                    default: s = $sformatf("%0h", v & 15);
                endcase
            end
            default: begin
                s = ($urandom_range(0, 1) == 0) ? random_word($urandom_range(1, 8))
                                                : decimal_text($urandom_range(0, 9999));
            end
        endcase
        return s;
    endfunction

    // Mostly well-formed lines with random content, the rest noise
    function automatic void build_line(ref logic [CH_W-1:0] q[$]);
        t_command cmd;
        int       n_params;
        string    name;
        q.delete();
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(0, 14)) q.push_back(8'($urandom_range(1, 255)));
            return;
        end
        case ($urandom_range(0, 6))
            0: begin cmd = OP_DISP;  name = "DISP";  end
            1: begin cmd = OP_FLICK; name = "FLICK"; end
            2: begin cmd = OP_LIGHT; name = "LIGHT"; end
            3: begin cmd = OP_CODE;  name = "CODE";  end
            4: begin cmd = OP_HELP;  name = "HELP";  end
            5: begin cmd = OP_NONE;  name = random_word($urandom_range(1, 9)); end
            default: begin
                cmd = OP_NONE;
                case ($urandom_range(0, 3))
                    0:       name = "DIS";
                    1:       name = "FLICKS";
                    2:       name = "LIGH";
                    default: name = "CODEX";
                endcase
            end
        endcase
        if ($urandom_range(0, 19) == 0) q.push_back(CH_SPACE);
        push_str(q, name, 1'b1);
        n_params = $urandom_range(0, 6);
        for (int k = 0; k < n_params; k++) begin
            q.push_back(CH_SPACE);
            push_str(q, param_text(cmd), 1'b1);
        end
        if ($urandom_range(0, 15) == 0) q.push_back(CH_SPACE);
    endfunction

    function automatic logic [VALUE_W-1:0] random_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return VALUE_W'(9999);
            2:       return VALUE_W'($urandom_range(0, 20));
            default: return VALUE_W'($urandom_range(0, 9999));
        endcase
    endfunction

    task automatic test_reset_limits();
        send_text("flick 100 2000 0");
        send_text("LIGHT 10 11");
        wait_drain();
    endtask

    task automatic test_each_command();
        send_text("DISP 12ab");
        send_text("CoDe fF a 0 10");
        send_text("help");
        send_text("LIGHT 1 2 3 4");
        send_text("XYZ 1");
        wait_drain();
    endtask

    task automatic test_special_cases();
        logic [CH_W-1:0] q[$];
        send_text("");
        send_text(" 5");
        send_text("DISP  x");
        send_text("ABCDEFGHI");
        send_text("code 1 2 3 12345678");
        send_text("light 1 2 3 4 extra");
        send_text("flick 12345");
        send_text("light 1a");
        send_text("code 123");
        q = '{8'hFF, 8'h80, 8'h7F, 8'h01};
        send_line(q);
        wait_drain();
    endtask

    task automatic test_limit_extremes();
        set_limits('0, '0, '0);
        send_text("flick 0 1");
        send_text("light 0");
        wait_drain();
        set_limits(VALUE_W'(9999), VALUE_W'(9999), VALUE_W'(9999));
        send_text("flick 9999 0");
        send_text("light 9999");
        wait_drain();
        set_limits(VALUE_W'(9999), '0, VALUE_W'(10));
        send_text("flick 5000");
        wait_drain();
    endtask

    // Hold the receiver off while lines keep coming, then drain
    task automatic test_backpressure();
        logic [CH_W-1:0] q[$];
        set_limits(VALUE_W'(100), VALUE_W'(2000), VALUE_W'(10));
        hold_req = 1'b1;
        repeat (6) begin
            build_line(q);
            send_line(q);
        end
        wait_drain();
    endtask

    task automatic test_random_lines(input int target);
        logic [CH_W-1:0] q[$];
        int              stop_at;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drain();
            case (phase)
                0:       set_limits(VALUE_W'(100), VALUE_W'(2000), VALUE_W'(10));
                1:       set_limits('0, VALUE_W'(9999), VALUE_W'(9999));
                2:       set_limits(VALUE_W'(9999), VALUE_W'(9999), '0);
                default: set_limits(random_limit(), random_limit(), random_limit());
            endcase
            gaps_on = (phase % 3 != 2);
            stop_at = chars_sent + target / RANDOM_PHASES;
            while (chars_sent < stop_at) begin
                build_line(q);
                send_line(q);
            end
        end
        wait_drain();
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.ch     <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_FLICK_MIN;
        cfg_if.data  <= '0;
        flick_lo    = FLICK_MIN_RESET;
        flick_hi    = FLICK_MAX_RESET;
        light_hi    = LIGHT_MAX_RESET;
        chars_sent  = 0;
        mismatches  = 0;
        cycle_count = 0;
        burst_left  = 1;
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        clear_line_state();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_limits();
        test_each_command();
        test_special_cases();
        test_limit_extremes();
        test_backpressure();
        test_random_lines(RANDOM_CHARS);

        // Let any late result word show up before the verdict
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending_lines.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
